FILE: rtl/core/idll_pkg.sv
// ============================================================================
// idll_pkg : shared definitions for the indexed doubly linked list
// Request and status codes, the result record and fixed port widths.
// ============================================================================
package idll_pkg;

    // Request codes carried in req_type
    localparam logic [1:0] REQ_AFTER  = 2'd0;
    localparam logic [1:0] REQ_BEFORE = 2'd1;
    localparam logic [1:0] REQ_DELETE = 2'd2;

    // Status codes returned with every result
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_RANGE = 2'd1;
    localparam logic [1:0] STAT_HEAD  = 2'd2;
    localparam logic [1:0] STAT_FULL  = 2'd3;

    // Fixed field widths of a request and a result
    localparam int REQ_W    = 2;
    localparam int POS_W    = 8;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 8;
    localparam int COUNT_W  = 8;

    // Result beat: status, slot, count from the lowest bit up
    localparam int OUT_TDATA_W = ((STATUS_W + SLOT_W + COUNT_W + 7) / 8) * 8;

    typedef struct packed {
        logic [COUNT_W-1:0]  count;
        logic [SLOT_W-1:0]   slot;
        logic [STATUS_W-1:0] status;
    } result_t;

endpackage

FILE: rtl/core/idll_ram.sv
// ============================================================================
// idll_ram : simple dual-port synchronous RAM
// One write port and one read port, read data registered.
// ============================================================================
module idll_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/idll_ctrl.sv
// ============================================================================
// idll_ctrl : request sequencer for the indexed doubly linked list
// Reads the link memories, decides the status, writes back the new links
// in the LOOK and FIN states and holds the result beat until it is taken.
// ============================================================================
module idll_ctrl #(
    parameter int SLOTS      = 256,
    parameter int VALUE_BITS = 32,
    localparam int IW        = $clog2(SLOTS)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // request side
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            req_type,
    input  logic [7:0]            position,
    input  logic [VALUE_BITS-1:0] value,
    // result side
    output logic                  out_valid,
    input  logic                  out_ready,
    output idll_pkg::result_t     result,
    // next-link memory
    output logic                  n_we,
    output logic [IW-1:0]         n_waddr,
    output logic [IW-1:0]         n_wdata,
    output logic [IW-1:0]         n_raddr,
    input  logic [IW-1:0]         n_rdata,
    // prev-link memory, occupied flag in the top bit
    output logic                  p_we,
    output logic [IW-1:0]         p_waddr,
    output logic [IW:0]           p_wdata,
    output logic [IW-1:0]         p_raddr,
    input  logic [IW:0]           p_rdata
);

    localparam int PW = (IW > 8) ? IW : 8;
    localparam logic [IW-1:0] LAST_SLOT = IW'(SLOTS - 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_LOOK = 3'b010,
        ST_FIN  = 3'b100
    } state_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_AFTER,
        OP_BEFORE,
        OP_DELETE
    } op_t;

    state_t                  state_reg, state_next;
    op_t                     op_reg, look_op;
    logic [1:0]              stat_reg, look_stat;
    logic [1:0]              req_reg;
    logic [IW-1:0]           pos_reg;
    logic                    range_reg;
    logic [VALUE_BITS-1:0]   val_reg;
    logic [IW-1:0]           a_reg, b_reg;
    logic [IW-1:0]           fh_reg, fh_next;
    logic [IW:0]             hw_reg, hw_next;
    logic [IW-1:0]           cnt_reg, cnt_next;
    logic [IW-1:0]           nra_reg, pra_reg;
    logic                    n0_wr_reg, p0_wr_reg;
    logic                    out_valid_reg;
    idll_pkg::result_t       result_reg;

    logic                    in_fire;
    logic [PW-1:0]           pos_wide;
    logic [IW-1:0]           pos_idx;
    logic                    pos_range;
    logic [IW-1:0]           n_eff, prev_eff;
    logic                    occ_eff;
    logic                    is_del, is_ins;
    logic [PW-1:0]           slot_wide, cnt_wide;

    logic [VALUE_BITS-1:0]   elem_mem [SLOTS];

    assign in_ready  = (state_reg == ST_IDLE) && !out_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign pos_wide  = PW'(position);
    assign pos_idx   = pos_wide[IW-1:0];
    assign pos_range = 32'(position) >= 32'(SLOTS);

    // Slots at or above the high-water mark were never handed out: they still
    // hold the ascending free chain and are not occupied.
    always_comb
    begin
        if ({1'b0, nra_reg} >= hw_reg)
        begin
            n_eff = (nra_reg == LAST_SLOT) ? '0 : nra_reg + 1'b1;
        end
        else if (nra_reg == '0 && !n0_wr_reg)
        begin
            n_eff = '0;
        end
        else
        begin
            n_eff = n_rdata;
        end

        if (pra_reg == '0)
        begin
            occ_eff  = 1'b1;
            prev_eff = p0_wr_reg ? p_rdata[IW-1:0] : '0;
        end
        else
        begin
            occ_eff  = ({1'b0, pra_reg} < hw_reg) && p_rdata[IW];
            prev_eff = p_rdata[IW-1:0];
        end
    end

    assign is_del = (req_reg == idll_pkg::REQ_DELETE);
    assign is_ins = (req_reg == idll_pkg::REQ_AFTER) || (req_reg == idll_pkg::REQ_BEFORE);

    // Status decision, made once the reads of the named slot are back
    always_comb
    begin
        look_op   = OP_NONE;
        look_stat = idll_pkg::STAT_OK;
        if (is_del && !range_reg && pos_reg == '0)
        begin
            look_stat = idll_pkg::STAT_HEAD;
        end
        else if (!(is_del || is_ins) || range_reg || !occ_eff)
        begin
            look_stat = idll_pkg::STAT_RANGE;
        end
        else if (is_del)
        begin
            look_op = OP_DELETE;
        end
        else if (cnt_reg == LAST_SLOT)
        begin
            look_stat = idll_pkg::STAT_FULL;
        end
        else if (req_reg == idll_pkg::REQ_AFTER)
        begin
            look_op = OP_AFTER;
        end
        else
        begin
            look_op = OP_BEFORE;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        n_we       = 1'b0;
        n_waddr    = pos_reg;
        n_wdata    = '0;
        p_we       = 1'b0;
        p_waddr    = pos_reg;
        p_wdata    = '0;
        n_raddr    = (state_reg == ST_LOOK) ? fh_reg : pos_idx;
        p_raddr    = pos_idx;
        fh_next    = fh_reg;
        hw_next    = hw_reg;
        cnt_next   = cnt_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                // first half of the relink: neighbors of the named slot
                state_next = ST_FIN;
                case (look_op)
                    OP_DELETE:
                    begin
                        n_we    = 1'b1;
                        n_waddr = prev_eff;
                        n_wdata = n_eff;
                        p_we    = 1'b1;
                        p_waddr = n_eff;
                        p_wdata = {1'b1, prev_eff};
                    end
                    OP_AFTER:
                    begin
                        n_we    = 1'b1;
                        n_waddr = pos_reg;
                        n_wdata = fh_reg;
                        p_we    = 1'b1;
                        p_waddr = n_eff;
                        p_wdata = {1'b1, fh_reg};
                    end
                    OP_BEFORE:
                    begin
                        n_we    = 1'b1;
                        n_waddr = prev_eff;
                        n_wdata = fh_reg;
                        p_we    = 1'b1;
                        p_waddr = pos_reg;
                        p_wdata = {1'b1, fh_reg};
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_FIN:
            begin
                // second half: the slot that moves between list and free chain
                state_next = ST_IDLE;
                case (op_reg)
                    OP_DELETE:
                    begin
                        n_we     = 1'b1;
                        n_waddr  = pos_reg;
                        n_wdata  = fh_reg;
                        p_we     = 1'b1;
                        p_waddr  = pos_reg;
                        p_wdata  = '0;
                        fh_next  = pos_reg;
                        cnt_next = cnt_reg - 1'b1;
                    end
                    OP_AFTER, OP_BEFORE:
                    begin
                        n_we     = 1'b1;
                        n_waddr  = fh_reg;
                        n_wdata  = (op_reg == OP_AFTER) ? b_reg : pos_reg;
                        p_we     = 1'b1;
                        p_waddr  = fh_reg;
                        p_wdata  = {1'b1, (op_reg == OP_AFTER) ? pos_reg : a_reg};
                        fh_next  = n_eff;
                        cnt_next = cnt_reg + 1'b1;
                        if ({1'b0, fh_reg} >= hw_reg)
                        begin
                            hw_next = {1'b0, fh_reg} + 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign slot_wide = PW'(fh_reg);
    assign cnt_wide  = PW'(cnt_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fh_reg        <= IW'(1);
            hw_reg        <= (IW + 1)'(1);
            cnt_reg       <= '0;
            n0_wr_reg     <= 1'b0;
            p0_wr_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            op_reg        <= OP_NONE;
        end
        else
        begin
            state_reg <= state_next;
            fh_reg    <= fh_next;
            hw_reg    <= hw_next;
            cnt_reg   <= cnt_next;
            if (n_we && n_waddr == '0)
            begin
                n0_wr_reg <= 1'b1;
            end
            if (p_we && p_waddr == '0)
            begin
                p0_wr_reg <= 1'b1;
            end
            if (state_reg == ST_LOOK)
            begin
                op_reg <= look_op;
            end
            if (state_reg == ST_FIN)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        nra_reg <= n_raddr;
        pra_reg <= p_raddr;
        if (in_fire)
        begin
            req_reg   <= req_type;
            pos_reg   <= pos_idx;
            range_reg <= pos_range;
            val_reg   <= value;
        end
        if (state_reg == ST_LOOK)
        begin
            stat_reg <= look_stat;
            a_reg    <= prev_eff;
            b_reg    <= n_eff;
        end
        if (state_reg == ST_FIN)
        begin
            result_reg.status <= stat_reg;
            result_reg.slot   <= (op_reg == OP_AFTER || op_reg == OP_BEFORE) ?
                                 slot_wide[7:0] : 8'd0;
            result_reg.count  <= cnt_wide[7:0];
        end
    end

    // Element store: written by every successful insert
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FIN && (op_reg == OP_AFTER || op_reg == OP_BEFORE))
        begin
            elem_mem[fh_reg] <= val_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

FILE: rtl/core/indexed_doubly_linked_list_top.sv
// ============================================================================
// indexed_doubly_linked_list_top : circular doubly linked list in slot memory
// Insert after, insert before and delete by slot index, with a free chain.
// ============================================================================
// Each request beat is answered by exactly one result beat. Between one
// accepted beat and the next, when results are taken at once, the block
// reads the named slot's links, reads the free chain head while the
// neighbors are relinked, relinks the moved slot and offers the result
// beat. This order is set by the dependent read-then-write chain through
// the single read port of each link memory. A new request is accepted
// only while no result beat is pending. There is no clearing pass after
// reset: slots that were never handed out are tracked by a high-water
// mark and read as the ascending free chain, so the block is ready for a
// request as soon as reset is released.
// ============================================================================
module indexed_doubly_linked_list_top #(
    parameter int SLOTS      = 256,
    parameter int VALUE_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // request beat: req_type[1:0], position[9:2], value[VALUE_BITS+9:10]
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [((VALUE_BITS+17)/8)*8-1:0]    s_axis_tdata,
    // result beat: status[1:0], slot[9:2], count[17:10]
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [idll_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    localparam int IW          = $clog2(SLOTS);
    localparam int IN_TDATA_W  = ((VALUE_BITS + 17) / 8) * 8;
    localparam int RES_W       = idll_pkg::STATUS_W + idll_pkg::SLOT_W + idll_pkg::COUNT_W;

    logic [1:0]              req_type;
    logic [7:0]              position;
    logic [VALUE_BITS-1:0]   value;
    idll_pkg::result_t       result;

    logic                    n_we, p_we;
    logic [IW-1:0]           n_waddr, n_wdata, n_raddr, n_rdata;
    logic [IW-1:0]           p_waddr, p_raddr;
    logic [IW:0]             p_wdata, p_rdata;

    // Unpack the request beat
    assign req_type = s_axis_tdata[1:0];
    assign position = s_axis_tdata[9:2];
    assign value    = s_axis_tdata[10 +: VALUE_BITS];

    // Sequencer: owns free chain head, counts and the result register
    idll_ctrl #(
        .SLOTS      (SLOTS),
        .VALUE_BITS (VALUE_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .req_type  (req_type),
        .position  (position),
        .value     (value),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .result    (result),
        .n_we      (n_we),
        .n_waddr   (n_waddr),
        .n_wdata   (n_wdata),
        .n_raddr   (n_raddr),
        .n_rdata   (n_rdata),
        .p_we      (p_we),
        .p_waddr   (p_waddr),
        .p_wdata   (p_wdata),
        .p_raddr   (p_raddr),
        .p_rdata   (p_rdata)
    );

    // Forward links; also threads the free chain
    idll_ram #(
        .DEPTH (SLOTS),
        .WIDTH (IW)
    ) u_next_ram (
        .clk   (clk),
        .we    (n_we),
        .waddr (n_waddr),
        .wdata (n_wdata),
        .raddr (n_raddr),
        .rdata (n_rdata)
    );

    // Backward links with the occupied flag on top
    idll_ram #(
        .DEPTH (SLOTS),
        .WIDTH (IW + 1)
    ) u_prev_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    // Pack the result beat, zero fill to a whole byte
    assign m_axis_tdata = {{(idll_pkg::OUT_TDATA_W - RES_W){1'b0}}, result};

endmodule

FILE: rtl/core/idll_checker.sv
// ============================================================================
// idll_checker : port-level checks for the indexed doubly linked list
// Watches the request and result beats and their timing.
// ============================================================================
module idll_checker #(
    parameter int IN_W = 48
) (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [IN_W-1:0]                  s_axis_tdata,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [idll_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    logic s_fire;

    assign s_fire = s_axis_tvalid && s_axis_tready;

    // hold a result beat until it is taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped before it was taken");

    // never take a request while a result is pending
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("request accepted while a result is pending");

    // every request yields its result once the link reads and writes are done
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> !s_axis_tready && !m_axis_tvalid ##1 !m_axis_tvalid ##1 m_axis_tvalid)
        else $error("result beat not produced on time");

    // failed requests report slot zero
    a_err_slot: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] != idll_pkg::STAT_OK |-> m_axis_tdata[9:2] == 8'd0)
        else $error("error result carries a slot");

    // a successful insert never hands out the head slot
    a_ins_slot: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire && s_axis_tdata[1:0] != idll_pkg::REQ_DELETE
        |-> ##3 (m_axis_tdata[1:0] != idll_pkg::STAT_OK || m_axis_tdata[9:2] != 8'd0
                 || m_axis_tdata[17:10] == 8'd0))
        else $error("insert reported the head slot");

endmodule

bind indexed_doubly_linked_list_top idll_checker #(
    .IN_W (IN_TDATA_W)
) u_idll_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
